// ===== sv/pps_pkg.sv =====
// shared types and codes for the ping-pong sample playback unit
// no dependencies; every other file but pps_chan_if refers to this package by scoped names
package pps_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic CFG_TRACK_START = 1'b0;
    localparam logic CFG_TRACK_LEN   = 1'b1;

    localparam int CFG_DATA_W   = 32;
    localparam int SECTOR_W     = 32;
    localparam int TRACK_LEN_W  = 24;
    localparam int SAMPLE_W     = 8;
    localparam int OFFSET_W     = 9;
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] fill_data;
        logic [OFFSET_W-1:0] fill_offset;
        logic                fill_front;
        logic                fill_last;
    } t_in;

    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic                stalled;
        logic                refill_request;
        logic [SECTOR_W-1:0] refill_sector;
        logic                refill_from_start;
    } t_out;

    // classified item handed from the front to the back
    typedef struct packed {
        t_mode               op;
        logic                wr_en;
        logic                set_ready;
        logic                fill_front;
        logic [SAMPLE_W-1:0] fill_data;
        logic [OFFSET_W-1:0] fill_offset;
    } t_cmd;

endpackage

// ===== sv/pps_chan_if.sv =====
// valid/ready channel carrying one payload of type T
// used with pps_pkg::t_in and pps_pkg::t_out
interface pps_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport mon    (input valid, input data, input ready);
endinterface

// ===== sv/pps_front.sv =====
// front stage: accepts input items and classifies them into commands
// depends on pps_pkg and pps_chan_if
module pps_front #(
    parameter int BUFFER_BYTES = 512
) (
    pps_chan_if.sink          i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output pps_pkg::t_cmd     o_cmd
);

    pps_pkg::t_mode op;
    logic           in_range;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    assign op       = pps_pkg::t_mode'(i_in.data.mode);
    assign in_range = 32'(i_in.data.fill_offset) < BUFFER_BYTES;

    always_comb begin
        o_cmd             = '0;
        o_cmd.op          = op;
        o_cmd.fill_front  = i_in.data.fill_front;
        o_cmd.fill_data   = i_in.data.fill_data;
        o_cmd.fill_offset = i_in.data.fill_offset;
        // offsets past the buffer write nothing, last still counts
        o_cmd.wr_en       = (op == pps_pkg::MODE_FILL) && in_range;
        o_cmd.set_ready   = (op == pps_pkg::MODE_FILL) && !i_in.data.fill_front
                            && i_in.data.fill_last;
    end

endmodule

// ===== sv/pps_cmd_queue.sv =====
// short command queue between the front and back stages
// depends on pps_pkg
module pps_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pps_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pps_pkg::t_cmd o_cmd
);

    localparam int DEPTH = pps_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pps_pkg::t_cmd   r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/pps_back.sv =====
// back stage: playback state, sample buffers, config registers, result register
// depends on pps_pkg and pps_chan_if
module pps_back #(
    parameter int BUFFER_BYTES = 512,
    parameter int INDEX_BITS   = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_cmd_valid,
    input  pps_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    pps_chan_if.source                        o_out
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int SW = pps_pkg::SECTOR_W;

    // both buffers in one memory, top address bit picks the buffer
    logic [pps_pkg::SAMPLE_W-1:0] r_mem [2*BUFFER_BYTES];
    logic [pps_pkg::SAMPLE_W-1:0] r_rd_data;

    logic [SW-1:0]                   r_track_start;
    logic [pps_pkg::TRACK_LEN_W-1:0] r_track_len;
    logic                            r_front_sel, n_front_sel;
    logic [INDEX_BITS-1:0]           r_play_idx,  n_play_idx;
    logic                            r_playing,   n_playing;
    logic                            r_ready,     n_ready;

    logic                            r_o_valid;
    pps_pkg::t_out                   r_o_meta,    n_o_meta;
    logic                            r_o_from_mem;

    logic                  fire;
    logic                  is_tick;
    logic                  at_wrap, at_bound, at_swap;
    logic                  stall, play;
    logic [INDEX_BITS-1:0] idx_now;
    logic [AW:0]           rd_addr, wr_addr;
    logic [SW-1:0]         next_sector;

    assign fire  = i_cmd_valid && (!r_o_valid || o_out.ready);
    assign o_pop = fire;

    assign is_tick  = i_cmd.op == pps_pkg::MODE_TICK;
    assign at_wrap  = 32'(r_play_idx) == 32'(r_track_len);
    assign at_bound = (r_play_idx != '0) && (r_play_idx[AW-1:0] == '0);
    assign at_swap  = at_wrap || at_bound;
    assign stall    = is_tick && r_playing && at_swap && !r_ready;
    assign play     = is_tick && r_playing && !stall;
    assign idx_now  = at_wrap ? '0 : r_play_idx;

    assign next_sector = r_track_start + SW'(r_play_idx >> AW) + SW'(1);
    assign rd_addr     = {n_front_sel, idx_now[AW-1:0]};
    assign wr_addr     = {i_cmd.fill_front ? r_front_sel : !r_front_sel,
                          AW'(i_cmd.fill_offset)};

    always_comb begin
        n_front_sel = r_front_sel;
        n_play_idx  = r_play_idx;
        n_playing   = r_playing;
        n_ready     = r_ready;
        n_o_meta    = '0;
        case (i_cmd.op)
            pps_pkg::MODE_TICK: begin
                if (stall) begin
                    n_o_meta.stalled = 1'b1;
                end else if (play) begin
                    n_o_meta.sample_valid = 1'b1;
                    n_play_idx = idx_now + 1'b1;
                    if (at_swap) begin
                        n_front_sel = !r_front_sel;
                        n_ready     = 1'b0;
                        n_o_meta.refill_request    = 1'b1;
                        n_o_meta.refill_from_start = at_wrap;
                        n_o_meta.refill_sector     = at_wrap ? r_track_start : next_sector;
                    end
                end
            end
            pps_pkg::MODE_FILL: begin
                if (i_cmd.set_ready) begin
                    n_ready = 1'b1;
                end
            end
            pps_pkg::MODE_START: begin
                n_play_idx = '0;
                n_ready    = 1'b1;
                n_playing  = 1'b1;
            end
            pps_pkg::MODE_STOP: begin
                n_playing = 1'b0;
                n_o_meta.sample_valid = 1'b1;
            end
            default: begin
                n_playing = r_playing;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_start <= '0;
            r_track_len   <= pps_pkg::TRACK_LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pps_pkg::CFG_TRACK_START: r_track_start <= i_cfg_data;
                pps_pkg::CFG_TRACK_LEN:   r_track_len   <= i_cfg_data[pps_pkg::TRACK_LEN_W-1:0];
                default:                  r_track_start <= r_track_start;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_sel <= 1'b0;
            r_play_idx  <= '0;
            r_playing   <= 1'b0;
            r_ready     <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_front_sel <= n_front_sel;
                r_play_idx  <= n_play_idx;
                r_playing   <= n_playing;
                r_ready     <= n_ready;
            end
            if (fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result payload and buffer access
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_meta     <= n_o_meta;
            r_o_from_mem <= play;
        end
        if (fire && i_cmd.wr_en) begin
            r_mem[wr_addr] <= i_cmd.fill_data;
        end
        if (fire && play) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_out.data = r_o_meta;
        if (r_o_from_mem) begin
            o_out.data.sample = r_rd_data;
        end
    end
    assign o_out.valid = r_o_valid;

endmodule

// ===== sv/ping_pong_sample_playback_unit.sv =====
// ping-pong sample playback unit, top level
// depends on pps_pkg, pps_chan_if, pps_front, pps_cmd_queue and pps_back
//
// i_in_ch carries items: sample tick, fill byte, start or stop. Every accepted
// item gives exactly one result on o_out_ch, in order. Fill bytes land in the
// front or back buffer; a tick plays one byte of the front buffer and, at a
// buffer boundary or at track end, swaps buffers and asks for a refill sector.
// A tick that needs a swap before the back buffer is refilled reports stalled.
// The track start sector and length must be written on the i_cfg_* port only while
// the unit is idle; the unit itself does not enforce this.
// Each result passes through the command queue and the result register.
// The unit takes one item per cycle while the command queue is not full, set by
// the single buffer read or write and the index update done in the back stage.
// A two-entry command queue sits between the front and back stages, and the
// result register holds while o_out_ch is stalled; the input keeps being taken
// until the queue is full.
// Reset stops playback, clears the index, the ready flag and the queue, and
// puts buffer zero in front. Buffer contents are undefined until written.
module ping_pong_sample_playback_unit #(
    parameter int BUFFER_BYTES = 512,
    parameter int INDEX_BITS   = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pps_chan_if.sink                       i_in_ch,
    pps_chan_if.source                     o_out_ch
);

    logic          q_full;
    logic          push;
    pps_pkg::t_cmd push_cmd;
    logic          pop;
    logic          head_valid;
    pps_pkg::t_cmd head_cmd;

    pps_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_in     (i_in_ch),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    pps_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    pps_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out       (o_out_ch)
    );

endmodule

// ===== sv/pps_checker.sv =====
// port-level checks on the result channel of the playback unit
// depends on pps_pkg; bound to ping_pong_sample_playback_unit
module pps_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          i_ready,
    input pps_pkg::t_out i_data
);

    // a stalled result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("result changed while stalled");

    // nothing is shown in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled tick plays nothing and asks for nothing
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.stalled |->
            !i_data.sample_valid && !i_data.refill_request)
        else $error("stalled tick with sample or request");

    // a refill request only comes with a played sample
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.refill_request |-> i_data.sample_valid)
        else $error("refill request without sample");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.refill_from_start |-> i_data.refill_request)
        else $error("track-start flag without request");

endmodule

bind ping_pong_sample_playback_unit pps_checker u_pps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out_ch.valid),
    .i_ready (o_out_ch.ready),
    .i_data  (o_out_ch.data)
);

// ===== dv/tb.sv =====
// testbench for ping_pong_sample_playback_unit: random bursts of ticks, fills,
// starts and stops, checked against an in-bench playback predictor
// depends on pps_pkg, pps_chan_if and the unit's rtl
module tb;

    localparam int BUF_BYTES = 512;
    localparam int IDX_W     = 24;
    localparam int LIMIT     = 400000;
    localparam int MAX_PRINT = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pps_chan_if #(.T(pps_pkg::t_in))  in_ch ();
    pps_chan_if #(.T(pps_pkg::t_out)) out_ch ();

    ping_pong_sample_playback_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // predictor state
    logic [7:0]                   buf_zero [BUF_BYTES];
    logic [7:0]                   buf_one  [BUF_BYTES];
    logic                         m_front;
    logic [IDX_W-1:0]             m_index;
    logic                         m_playing;
    logic                         m_ready;
    logic [pps_pkg::SECTOR_W-1:0] m_track_start;
    logic [IDX_W-1:0]             m_track_len;

    pps_pkg::t_in  pending_items[$];
    pps_pkg::t_out expected_results[$];

    logic in_fire;
    int   gap_left, burst_left;
    int   rx_cnt, rx_mode;
    int   cycles;
    int   errors, printed;
    int   n_items, n_samples, n_stalls, n_requests, n_from_start, n_settings;
    logic gen_playing;

    function automatic pps_pkg::t_out playback_step(pps_pkg::t_in it);
        pps_pkg::t_out r;
        logic          ok;
        r  = '0;
        ok = 1'b1;
        case (pps_pkg::t_mode'(it.mode))
            pps_pkg::MODE_TICK: begin
                if (m_playing) begin
                    if (m_index == m_track_len) begin
                        if (!m_ready) begin
                            r.stalled = 1'b1;
                            ok        = 1'b0;
                        end else begin
                            m_front             = ~m_front;
                            m_ready             = 1'b0;
                            m_index             = '0;
                            r.refill_request    = 1'b1;
                            r.refill_sector     = m_track_start;
                            r.refill_from_start = 1'b1;
                        end
                    end
                    if (ok && m_index != 0 && (m_index % BUF_BYTES) == 0) begin
                        if (!m_ready) begin
                            r.stalled = 1'b1;
                            ok        = 1'b0;
                        end else begin
                            m_front          = ~m_front;
                            m_ready          = 1'b0;
                            r.refill_request = 1'b1;
                            r.refill_sector  = m_track_start
                                + pps_pkg::SECTOR_W'(m_index / BUF_BYTES) + 32'd1;
                        end
                    end
                    if (ok) begin
                        r.sample_valid = 1'b1;
                        r.sample = m_front ? buf_one[m_index[8:0]]
                                           : buf_zero[m_index[8:0]];
                        m_index = m_index + 1'b1;
                    end
                end
            end
            pps_pkg::MODE_FILL: begin
                // front fill hits the buffer now playing, back fill the other one
                if (it.fill_front ^ m_front)
                    buf_zero[it.fill_offset] = it.fill_data;
                else
                    buf_one[it.fill_offset] = it.fill_data;
                if (!it.fill_front && it.fill_last)
                    m_ready = 1'b1;
            end
            pps_pkg::MODE_START: begin
                m_index   = '0;
                m_ready   = 1'b1;
                m_playing = 1'b1;
            end
            default: begin
                m_playing      = 1'b0;
                r.sample_valid = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (printed < MAX_PRINT) begin
                printed++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endtask

    task automatic push_item(pps_pkg::t_mode mode, logic [7:0] data,
                             logic [8:0] offset, logic front, logic last);
        pps_pkg::t_in it;
        it.mode        = mode;
        it.fill_data   = data;
        it.fill_offset = offset;
        it.fill_front  = front;
        it.fill_last   = last;
        pending_items.push_back(it);
        if (mode == pps_pkg::MODE_START)
            gen_playing = 1'b1;
        else if (mode == pps_pkg::MODE_STOP)
            gen_playing = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // both writes happen with the unit idle, so the predictor copy is updated now
    task automatic set_track(logic [31:0] start_sector, logic [23:0] length);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pps_pkg::CFG_TRACK_START;
        i_cfg_data  <= start_sector;
        m_track_start = start_sector;
        @(negedge i_clk);
        i_cfg_index <= pps_pkg::CFG_TRACK_LEN;
        i_cfg_data  <= {8'h00, length};
        m_track_len = length;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic make_phase(int count);
        int         k, r, len;
        logic [8:0] off;
        k = 0;
        while (k < count) begin
            r = $urandom_range(0, 999);
            if (!gen_playing && $urandom_range(0, 2) == 0) begin
                push_item(pps_pkg::MODE_START, 8'($urandom), 9'($urandom),
                          1'($urandom), 1'($urandom));
                k++;
            end else if (r < 700) begin
                push_item(pps_pkg::MODE_TICK, 8'($urandom), 9'($urandom),
                          1'($urandom), 1'($urandom));
                k++;
            end else if (r < 860) begin
                push_item(pps_pkg::MODE_FILL, 8'($urandom), 9'($urandom), 1'b0,
                          $urandom_range(0, 5) == 0);
                k++;
            end else if (r < 880) begin
                // orderly refill: consecutive back-buffer bytes closed by a last
                len = $urandom_range(4, 24);
                off = 9'($urandom);
                for (int j = 0; j < len; j++)
                    push_item(pps_pkg::MODE_FILL, 8'($urandom), off + 9'(j), 1'b0,
                              j == len - 1);
                k += len;
            end else if (r < 990) begin
                push_item(pps_pkg::MODE_FILL, 8'($urandom), 9'($urandom), 1'b1,
                          1'($urandom));
                k++;
            end else if (r < 995) begin
                push_item(pps_pkg::MODE_STOP, 8'($urandom), 9'($urandom),
                          1'($urandom), 1'($urandom));
                k++;
            end else begin
                push_item(pps_pkg::MODE_START, 8'($urandom), 9'($urandom),
                          1'($urandom), 1'($urandom));
                k++;
            end
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = pps_pkg::CFG_TRACK_START;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b1;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        m_front       = 1'b0;
        m_index       = '0;
        m_playing     = 1'b0;
        m_ready       = 1'b0;
        m_track_start = '0;
        m_track_len   = 24'd1;
        gen_playing   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_track(32'hFFFF_FFFF, 24'd2);
        // preload both buffers completely so every played byte was written
        for (int j = 0; j < BUF_BYTES; j++)
            push_item(pps_pkg::MODE_FILL, (j == 0) ? 8'h00 : (j == BUF_BYTES - 1) ? 8'hFF
                      : 8'($urandom), 9'(j), 1'b1, 1'b0);
        for (int j = 0; j < BUF_BYTES; j++)
            push_item(pps_pkg::MODE_FILL, (j == 0) ? 8'hFF : (j == BUF_BYTES - 1) ? 8'h00
                      : 8'($urandom), 9'(j), 1'b0, 1'b0);

        // tick while stopped, track wrap with and without refill ready
        push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_START, 8'h00, 9'd0, 1'b0, 1'b0);
        repeat (5) push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        // last on a front fill does not release the stall
        push_item(pps_pkg::MODE_FILL, 8'hFF, 9'd511, 1'b1, 1'b1);
        push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_FILL, 8'h00, 9'd0, 1'b0, 1'b1);
        push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_STOP, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        // last with nothing pending sets the ready flag; the start that follows sets it as well
        push_item(pps_pkg::MODE_FILL, 8'h5A, 9'd511, 1'b0, 1'b1);
        push_item(pps_pkg::MODE_START, 8'h00, 9'd0, 1'b0, 1'b0);
        repeat (3) push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_FILL, 8'hA5, 9'd5, 1'b1, 1'b0);
        push_item(pps_pkg::MODE_STOP, 8'h00, 9'd0, 1'b0, 1'b0);
        wait_idle();

        // play across a buffer boundary so the swap asks for the next sector
        set_track(32'h1234_5678, 24'd600);
        push_item(pps_pkg::MODE_START, 8'h00, 9'd0, 1'b0, 1'b0);
        repeat (BUF_BYTES + 3) push_item(pps_pkg::MODE_TICK, 8'h00, 9'd0, 1'b0, 1'b0);
        push_item(pps_pkg::MODE_STOP, 8'h00, 9'd0, 1'b0, 1'b0);
        wait_idle();

        set_track(32'h0000_0000, 24'd1);
        make_phase(32);
        wait_idle();
        set_track(32'hFFFF_FFFF, 24'd0);
        make_phase(32);
        wait_idle();
        set_track($urandom, 24'd700);
        make_phase(32);
        wait_idle();
        set_track(32'hFFFF_FFFE, 24'hFF_FFFF);
        make_phase(32);
        wait_idle();
        set_track($urandom, 24'd513);
        make_phase(32);
        wait_idle();
        set_track($urandom, 24'($urandom_range(2, 1100)));
        make_phase(32);
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("run: %0d items over %0d track settings, %0d samples, %0d stalled ticks",
                 n_items, n_settings, n_samples, n_stalls);
        $display("run: %0d refill requests, %0d of them track-start reloads",
                 n_requests, n_from_start);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin : drive_items
        pps_pkg::t_in nxt_data;
        logic         nxt_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    = 0;
            burst_left  = 1;
        end else if (!in_ch.valid || in_fire) begin
            nxt_valid = 1'b0;
            nxt_data  = in_ch.data;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() != 0) begin
                nxt_data  = pending_items.pop_front();
                nxt_valid = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
            in_ch.valid <= nxt_valid;
            in_ch.data  <= nxt_data;
        end
    end

    // receiver: stall pattern is chosen at random from four modes and changes over the run
    always @(negedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt % 50 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= (rx_cnt % 4) != 0;
            default: out_ch.ready <= $urandom_range(0, 3) == 0;
        endcase
    end

    initial begin
        rx_cnt  = 0;
        rx_mode = 0;
        cycles  = 0;
        errors  = 0;
        printed = 0;
    end

    always @(posedge i_clk) begin : watch_results
        pps_pkg::t_out want, got;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(playback_step(in_ch.data));
                n_items++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (printed < MAX_PRINT) begin
                        printed++;
                        $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                                 $time, got);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("sample_valid", 32'(want.sample_valid),
                                32'(got.sample_valid));
                    check_field("sample", 32'(want.sample), 32'(got.sample));
                    check_field("stalled", 32'(want.stalled), 32'(got.stalled));
                    check_field("refill_request", 32'(want.refill_request),
                                32'(got.refill_request));
                    check_field("refill_sector", want.refill_sector, got.refill_sector);
                    check_field("refill_from_start", 32'(want.refill_from_start),
                                32'(got.refill_from_start));
                    n_samples    += 32'(want.sample_valid);
                    n_stalls     += 32'(want.stalled);
                    n_requests   += 32'(want.refill_request);
                    n_from_start += 32'(want.refill_from_start);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

// ===== ping_pong_sample_playback_unit.f =====
sv/pps_pkg.sv
sv/pps_chan_if.sv
sv/pps_front.sv
sv/pps_cmd_queue.sv
sv/pps_back.sv
sv/ping_pong_sample_playback_unit.sv
sv/pps_checker.sv
dv/tb.sv
